>>> rtl/core/sep_pkg.sv
// Shared types and codes for the sorted event priority queue.
package sep_pkg;

	// Operation codes carried in a request
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [31:0] time_key;
		logic [31:0] entry_payload;
	} sep_req_t;

	typedef struct packed {
		logic [1:0]  status_code;
		logic [31:0] removed_key;
		logic [31:0] removed_payload;
		logic [31:0] head_key;
		logic [31:0] head_payload;
		logic        is_empty;
		logic [4:0]  entry_count;
	} sep_res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_HEAD
	} sep_state_t;

endpackage

>>> rtl/core/sorted_event_priority_queue.sv
// Overflow, underflow, insert into empty, or remove leaving none finish from the idle state;
// other removes fetch the new head from the entry memory in the head state;
// inserts scan from the tail, shifting each larger stored key back, one memory entry a cycle.
// Throughput: a new request is taken in the cycle its result is shown.
// Reset clears state, count and head pointer; memory contents are not cleared.
// Results appear for one cycle on done; the receiver cannot stall them.
module sorted_event_priority_queue import sep_pkg::*; #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sep_req_t request,
	output logic     busy,
	output logic     done,
	output sep_res_t result
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                    fin;
	sep_res_t                res;
	logic                    we;
	logic                    re;
	logic [PTR_W-1:0]        waddr;
	logic [PTR_W-1:0]        raddr;
	logic [31:0]             wkey;
	logic [31:0]             rkey;
	logic [PAYLOAD_BITS-1:0] wpay;
	logic [PAYLOAD_BITS-1:0] rpay;
	logic                    done_q;
	sep_res_t                result_q;

	sep_ctrl #(
		.DEPTH (QUEUE_DEPTH),
		.PTR_W (PTR_W),
		.CNT_W (CNT_W),
		.PAY_W (PAYLOAD_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (request),
		.busy   (busy),
		.fin    (fin),
		.res    (res),
		.we     (we),
		.waddr  (waddr),
		.wkey   (wkey),
		.wpay   (wpay),
		.re     (re),
		.raddr  (raddr),
		.rkey   (rkey),
		.rpay   (rpay)
	);

	sep_mem #(
		.DEPTH (QUEUE_DEPTH),
		.PTR_W (PTR_W),
		.PAY_W (PAYLOAD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wkey  (wkey),
		.wpay  (wpay),
		.re    (re),
		.raddr (raddr),
		.rkey  (rkey),
		.rpay  (rpay)
	);

	// Register the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	// Hold the result fields
	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/sep_mem.sv
// Entry store: one write port and one registered read port.
module sep_mem import sep_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int PTR_W = 4,
	parameter int PAY_W = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] waddr,
	input  logic [31:0]      wkey,
	input  logic [PAY_W-1:0] wpay,
	input  logic             re,
	input  logic [PTR_W-1:0] raddr,
	output logic [31:0]      rkey,
	output logic [PAY_W-1:0] rpay
);

	logic [31:0]      key_mem [DEPTH];
	logic [PAY_W-1:0] pay_mem [DEPTH];

	// Write the entry
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			pay_mem[waddr] <= wpay;
		end
	end

	// Read the entry, registered; data ready in the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rkey <= key_mem[raddr];
			rpay <= pay_mem[raddr];
		end
	end

endmodule

>>> rtl/core/sep_ctrl.sv
// Queue sequencer: circular sorted list, tail-first insertion scan, head cache.
module sep_ctrl import sep_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int PTR_W = 4,
	parameter int CNT_W = 5,
	parameter int PAY_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sep_req_t         req,
	output logic             busy,
	output logic             fin,
	output sep_res_t         res,
	output logic             we,
	output logic [PTR_W-1:0] waddr,
	output logic [31:0]      wkey,
	output logic [PAY_W-1:0] wpay,
	output logic             re,
	output logic [PTR_W-1:0] raddr,
	input  logic [31:0]      rkey,
	input  logic [PAY_W-1:0] rpay
);

	sep_state_t       state_q, state_n;
	logic [PTR_W-1:0] hd_q, hd_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [PTR_W-1:0] lidx_q, lidx_n;
	logic [31:0]      key_q, key_n;
	logic [PAY_W-1:0] pay_q, pay_n;
	logic [31:0]      head_key_q, head_key_n;
	logic [PAY_W-1:0] head_pay_q, head_pay_n;
	logic [63:0]      pay_in_wide;
	logic [PAY_W-1:0] pay_in;
	logic [63:0]      rem_pay_wide;
	logic [63:0]      head_pay_wide;
	logic             is_rem;
	logic [1:0]       status;

	// Map a list position to a memory address behind the head
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
		input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign pay_in_wide = {32'd0, req.entry_payload};
	assign pay_in      = pay_in_wide[PAY_W-1:0];
	assign busy        = (state_q != S_IDLE);

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			hd_q    <= hd_n;
			cnt_q   <= cnt_n;
		end
	end

	// Hold the working entry, scan position and head cache
	always_ff @(posedge clk) begin
		lidx_q     <= lidx_n;
		key_q      <= key_n;
		pay_q      <= pay_n;
		head_key_q <= head_key_n;
		head_pay_q <= head_pay_n;
	end

	// Sequence one request
	always_comb begin
		state_n    = state_q;
		hd_n       = hd_q;
		cnt_n      = cnt_q;
		lidx_n     = lidx_q;
		key_n      = key_q;
		pay_n      = pay_q;
		head_key_n = head_key_q;
		head_pay_n = head_pay_q;
		we         = 1'b0;
		waddr      = hd_q;
		wkey       = key_q;
		wpay       = pay_q;
		re         = 1'b0;
		raddr      = hd_q;
		fin        = 1'b0;
		is_rem     = 1'b0;
		status     = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.operation == OP_INSERT) begin
						key_n = req.time_key;
						pay_n = pay_in;
						if (cnt_q == CNT_W'(DEPTH)) begin
							// refuse when full
							fin    = 1'b1;
							status = ST_OVERFLOW;
						end else if (cnt_q == '0) begin
							// first entry goes straight to the head
							we         = 1'b1;
							waddr      = hd_q;
							wkey       = req.time_key;
							wpay       = pay_in;
							head_key_n = req.time_key;
							head_pay_n = pay_in;
							cnt_n      = CNT_W'(1);
							fin        = 1'b1;
						end else begin
							// start the scan at the tail
							lidx_n  = PTR_W'(cnt_q - CNT_W'(1));
							re      = 1'b1;
							raddr   = phys(hd_q, PTR_W'(cnt_q - CNT_W'(1)));
							state_n = S_SCAN;
						end
					end else begin
						if (cnt_q == '0) begin
							fin    = 1'b1;
							status = ST_UNDERFLOW;
						end else begin
							// drop the head and fetch the next one if any remains
							is_rem = 1'b1;
							key_n  = head_key_q;
							pay_n  = head_pay_q;
							hd_n   = phys(hd_q, PTR_W'(1));
							cnt_n  = cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								fin = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = phys(hd_q, PTR_W'(1));
								state_n = S_HEAD;
							end
						end
					end
				end
			end
			S_SCAN: begin
				waddr = phys(hd_q, lidx_q + PTR_W'(1));
				we    = 1'b1;
				if (rkey > key_q) begin
					// shift the larger entry one place back
					wkey = rkey;
					wpay = rpay;
					if (lidx_q == '0) begin
						state_n = S_PLACE;
					end else begin
						lidx_n = lidx_q - PTR_W'(1);
						re     = 1'b1;
						raddr  = phys(hd_q, lidx_q - PTR_W'(1));
					end
				end else begin
					// place the new entry behind this one
					cnt_n   = cnt_q + CNT_W'(1);
					fin     = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_PLACE: begin
				// new entry becomes the head
				we         = 1'b1;
				waddr      = hd_q;
				head_key_n = key_q;
				head_pay_n = pay_q;
				cnt_n      = cnt_q + CNT_W'(1);
				fin        = 1'b1;
				state_n    = S_IDLE;
			end
			S_HEAD: begin
				// take the fetched entry as the new head
				is_rem     = 1'b1;
				head_key_n = rkey;
				head_pay_n = rpay;
				fin        = 1'b1;
				state_n    = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Assemble the result from the post-request state
	assign rem_pay_wide  = 64'(pay_n);
	assign head_pay_wide = 64'(head_pay_n);

	always_comb begin
		res.status_code     = status;
		res.removed_key     = is_rem ? key_n : 32'd0;
		res.removed_payload = is_rem ? rem_pay_wide[31:0] : 32'd0;
		res.head_key        = (cnt_n != '0) ? head_key_n : 32'd0;
		res.head_payload    = (cnt_n != '0) ? head_pay_wide[31:0] : 32'd0;
		res.is_empty        = (cnt_n == '0);
		res.entry_count     = 5'(cnt_n);
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_scan_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (cnt_q != '0) && (cnt_q < CNT_W'(DEPTH)))
		else $error("insertion scan without room or entries");

	a_head_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD |-> cnt_q != '0)
		else $error("head fetch on empty queue");

	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we && re |-> waddr != raddr)
		else $error("read and write to the same entry");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == S_IDLE)
		else $error("finished request left sequencer busy");
`endif

endmodule
